[design/llcp_agf_pkg.sv]
package llcp_agf_pkg;

    // Parser phases of one aggregated frame
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HDR2   = 3'd1,
        PH_LENHI  = 3'd2,
        PH_LENLO  = 3'd3,
        PH_FIRST  = 3'd4,
        PH_SECOND = 3'd5,
        PH_BODY   = 3'd6
    } t_phase;

    // Result codes
    typedef enum logic {
        KIND_PDU_BYTE  = 1'b0,
        KIND_MALFORMED = 1'b1
    } t_kind;

    // Sub-PDU types that are consumed here and never forwarded
    localparam logic [3:0] TYPE_SYMM = 4'h0;
    localparam logic [3:0] TYPE_AGF  = 4'h2;

    // Smallest legal sub-PDU length and outer frame length bound
    localparam logic [15:0] MIN_PDU = 16'd2;

    // Result queue depth and index widths
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_result;

endpackage

[design/llcp_aggregated_frame_splitter.sv]
// Splits an aggregated LLCP frame (AGF) into its sub-PDUs. Bytes enter one per
// beat, frame_start and frame_length marking the first byte of each frame. The
// 2-byte outer header is skipped, then each sub-PDU is read as a 16-bit
// big-endian length and its body; SYMM and AGF sub-PDUs are dropped, all others
// come out byte by byte with first and last marks. Bad lengths and frames of
// 2 bytes or less give one malformed report (result_kind 1), after which the
// rest of the frame is ignored. The input side takes one byte per cycle while
// o_in_stall is low: all parsing is a single pass from the parser state
// registers into a four-entry result queue, which holds each result until the
// output takes it. The second byte of a forwarded sub-PDU releases the held
// first byte too, so that byte yields two output beats; the input is stalled
// only while the result queue has fewer than two free entries.
module llcp_aggregated_frame_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    input  logic [15:0] i_frame_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_pdu_first,
    output logic        o_pdu_last
);

    localparam int unsigned QPTR_W = llcp_agf_pkg::QPTR_W;
    localparam int unsigned QCNT_W = llcp_agf_pkg::QCNT_W;

    // Parser state
    llcp_agf_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_frame_left, n_frame_left;
    logic [15:0] r_pdu_left, n_pdu_left;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [7:0]  r_held, n_held;
    logic        r_fwd, n_fwd;

    // Result queue
    llcp_agf_pkg::t_result r_queue [llcp_agf_pkg::QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic                  in_accept;
    logic                  out_pop;
    logic [1:0]            wr_cnt;
    llcp_agf_pkg::t_result res0, res1;
    logic [15:0]           plen;
    logic [3:0]            ptype;
    logic [15:0]           pdu_dec;
    logic [15:0]           frame_dec;

    assign o_in_stall = (r_count > QCNT_W'(llcp_agf_pkg::QDEPTH - 2));
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_pop    = o_out_valid && !i_out_stall;

    assign plen      = {r_len_hi, i_data_byte};
    assign ptype     = {r_held[1:0], i_data_byte[7:6]};
    assign pdu_dec   = r_pdu_left - 16'd1;
    assign frame_dec = r_frame_left - 16'd1;

    // Parse one byte: next state and up to two results
    always_comb begin
        n_phase      = r_phase;
        n_frame_left = r_frame_left;
        n_pdu_left   = r_pdu_left;
        n_len_hi     = r_len_hi;
        n_held       = r_held;
        n_fwd        = r_fwd;
        wr_cnt       = 2'd0;
        res0         = '{kind: llcp_agf_pkg::KIND_MALFORMED, data: 8'd0,
                         first: 1'b0, last: 1'b0};
        res1         = '{kind: llcp_agf_pkg::KIND_PDU_BYTE, data: i_data_byte,
                         first: 1'b0, last: (r_pdu_left == 16'd1)};
        if (in_accept) begin
            if (i_frame_start) begin
                // Open a new frame, abandoning any active one
                n_fwd      = 1'b0;
                n_pdu_left = 16'd0;
                if (i_frame_length <= llcp_agf_pkg::MIN_PDU) begin
                    wr_cnt       = 2'd1;
                    n_phase      = llcp_agf_pkg::PH_IDLE;
                    n_frame_left = 16'd0;
                end else begin
                    n_phase      = llcp_agf_pkg::PH_HDR2;
                    n_frame_left = i_frame_length - 16'd1;
                end
            end else if (r_phase == llcp_agf_pkg::PH_IDLE || r_frame_left == 16'd0) begin
                // Drop bytes outside a frame
                n_phase      = llcp_agf_pkg::PH_IDLE;
                n_frame_left = 16'd0;
            end else begin
                n_frame_left = frame_dec;
                unique case (r_phase)
                    llcp_agf_pkg::PH_HDR2: begin
                        n_phase = llcp_agf_pkg::PH_LENHI;
                    end
                    llcp_agf_pkg::PH_LENHI: begin
                        if (r_frame_left <= llcp_agf_pkg::MIN_PDU) begin
                            // Drop a short remainder silently
                            n_phase      = llcp_agf_pkg::PH_IDLE;
                            n_frame_left = 16'd0;
                        end else begin
                            n_len_hi = i_data_byte;
                            n_phase  = llcp_agf_pkg::PH_LENLO;
                        end
                    end
                    llcp_agf_pkg::PH_LENLO: begin
                        if (plen < llcp_agf_pkg::MIN_PDU || plen > frame_dec) begin
                            wr_cnt       = 2'd1;
                            n_phase      = llcp_agf_pkg::PH_IDLE;
                            n_frame_left = 16'd0;
                        end else begin
                            n_pdu_left = plen;
                            n_phase    = llcp_agf_pkg::PH_FIRST;
                        end
                    end
                    llcp_agf_pkg::PH_FIRST: begin
                        n_held     = i_data_byte;
                        n_pdu_left = pdu_dec;
                        n_phase    = llcp_agf_pkg::PH_SECOND;
                    end
                    llcp_agf_pkg::PH_SECOND: begin
                        // Type is known now: unless SYMM or AGF, release held byte and this one
                        n_fwd = (ptype != llcp_agf_pkg::TYPE_SYMM) &&
                                (ptype != llcp_agf_pkg::TYPE_AGF);
                        if (n_fwd) begin
                            wr_cnt = 2'd2;
                            res0   = '{kind: llcp_agf_pkg::KIND_PDU_BYTE, data: r_held,
                                       first: 1'b1, last: 1'b0};
                        end
                        n_pdu_left = pdu_dec;
                        n_phase    = (pdu_dec == 16'd0) ? llcp_agf_pkg::PH_LENHI
                                                        : llcp_agf_pkg::PH_BODY;
                    end
                    llcp_agf_pkg::PH_BODY: begin
                        if (r_fwd) begin
                            wr_cnt = 2'd1;
                            res0   = res1;
                        end
                        n_pdu_left = pdu_dec;
                        if (pdu_dec == 16'd0) begin
                            n_phase = llcp_agf_pkg::PH_LENHI;
                        end
                    end
                    default: begin
                        n_phase      = llcp_agf_pkg::PH_IDLE;
                        n_frame_left = 16'd0;
                    end
                endcase
                // Close the frame on its last byte
                if (n_frame_left == 16'd0) begin
                    n_phase = llcp_agf_pkg::PH_IDLE;
                end
            end
        end
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= llcp_agf_pkg::PH_IDLE;
            r_frame_left <= 16'd0;
            r_pdu_left   <= 16'd0;
            r_len_hi     <= 8'd0;
            r_held       <= 8'd0;
            r_fwd        <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_frame_left <= n_frame_left;
            r_pdu_left   <= n_pdu_left;
            r_len_hi     <= n_len_hi;
            r_held       <= n_held;
            r_fwd        <= n_fwd;
        end
    end

    // Push results into the queue
    always_ff @(posedge i_clk) begin
        if (wr_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (wr_cnt == 2'd2) begin
            r_queue[r_wr_ptr + QPTR_W'(1)] <= res1;
        end
    end

    // Advance queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_W'(wr_cnt);
            if (out_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(wr_cnt) - QCNT_W'(out_pop);
        end
    end

    // Present the queue head
    assign o_out_valid   = (r_count != '0);
    assign o_result_kind = r_queue[r_rd_ptr].kind;
    assign o_out_byte    = r_queue[r_rd_ptr].data;
    assign o_pdu_first   = r_queue[r_rd_ptr].first;
    assign o_pdu_last    = r_queue[r_rd_ptr].last;

    // Queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(llcp_agf_pkg::QDEPTH))
        else $error("result queue overflow");

    // Idle exactly when no frame bytes remain
    a_idle_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == llcp_agf_pkg::PH_IDLE) == (r_frame_left == 16'd0))
        else $error("phase and frame count disagree");

    // A malformed report carries no byte and no marks
    a_report_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind |-> o_out_byte == 8'd0 && !o_pdu_first && !o_pdu_last)
        else $error("malformed report carries payload");

    // A forwarded sub-PDU has at least two bytes
    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pdu_first |-> !o_pdu_last)
        else $error("sub-PDU first byte marked last");

    // Two results are written only on the second byte of a sub-PDU
    a_pair_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_cnt == 2'd2 |-> r_phase == llcp_agf_pkg::PH_SECOND && !i_frame_start)
        else $error("double result outside second byte");

endmodule
